// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge of clk_i outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true at a rising edge of clk_i outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== src/ctct_pkg.sv =====
// ----------------------------------------------------------------------------
// ctct_pkg
// Shared types and constants of the chroma threshold centroid tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctct_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned COUNT_W    = 21;
  localparam int unsigned WTOT_W     = 43;
  localparam int unsigned WSUM_W     = 53;
  localparam int unsigned CENTRE_W   = 10;
  localparam int unsigned PASS_W     = 16;
  localparam int unsigned MINW_W     = 40;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned QDEPTH     = 4;
  // numerator 2*sum + total needs two bits over the sum
  localparam int unsigned NUM_W      = WSUM_W + 2;
  localparam int unsigned DIV_CNT_W  = $clog2(CENTRE_W + 1);

  localparam logic [PIX_W-1:0]    THRESH_RESET = 8'd80;
  localparam logic [PIX_W-1:0]    GREY         = 8'd128;
  localparam logic                DIM_RESET    = 1'b1;
  localparam logic [PASS_W-1:0]   PASS_RESET   = 16'd655;
  localparam logic [MINW_W-1:0]   MINW_RESET   = 40'd4000;
  localparam logic [CENTRE_W-1:0] CENTRE_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM  = 2'd0,
    CFG_PASS = 2'd1,
    CFG_MINW = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_LOAD,
    BK_DIV,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [PIX_W-1:0] y;
    logic [PIX_W-1:0] u;
    logic [PIX_W-1:0] v;
  } pix_t;

  typedef struct packed {
    logic                dim;
    logic [PASS_W-1:0]   pass;
    logic [MINW_W-1:0]   minw;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic                found;
    logic [CENTRE_W-1:0] cx;
    logic [CENTRE_W-1:0] cy;
  } report_t;

endpackage

// ===== src/ctct_front.sv =====
// ----------------------------------------------------------------------------
// ctct_front
// Pixel classifier: threshold compare, dimming, run length, weight, raster position,
// frame statistics and threshold adaptation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ctct_front #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RUN    = 4095,
  localparam int unsigned COL_W = $clog2(MAX_WIDTH),
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT),
  localparam int unsigned RUN_W = $clog2(MAX_RUN + 1),
  localparam int unsigned WT_W  = 2 * RUN_W - 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  ctct_pkg::pix_t    pix_i,
  input  logic              line_end_i,
  input  logic              frame_end_i,
  input  ctct_pkg::cfg_t    cfg_i,
  output ctct_pkg::pix_t    pix_o,
  output logic [WT_W-1:0]   wt_o,
  output logic [COL_W-1:0]  col_o,
  output logic [ROW_W-1:0]  row_o
);
  import ctct_pkg::*;

  localparam int unsigned CMP_W = COUNT_W + PASS_W;

  logic [PIX_W-1:0]   thr_q, thr_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [COUNT_W-1:0] sel_cnt_q, sel_cnt_d;
  logic [COUNT_W-1:0] pix_cnt_q, pix_cnt_d;

  logic               sel;
  logic [RUN_W-1:0]   run_new;
  logic [COUNT_W-1:0] sel_cnt_new;
  logic [COUNT_W-1:0] pix_cnt_new;
  logic [CMP_W-1:0]   lhs;
  logic [CMP_W-1:0]   rhs;
  logic               below;

  always_comb begin
    sel = pix_i.u < thr_q;

    if (!sel) begin
      run_new = '0;
    end else if (run_q < RUN_W'(MAX_RUN)) begin
      run_new = run_q + 1'b1;
    end else begin
      run_new = run_q;
    end
    wt_o = WT_W'(run_new[RUN_W-1:2]) * WT_W'(run_new);

    sel_cnt_new = (sel && sel_cnt_q != '1) ? sel_cnt_q + 1'b1 : sel_cnt_q;
    pix_cnt_new = (pix_cnt_q != '1) ? pix_cnt_q + 1'b1 : pix_cnt_q;

    // selected/pixels < pass/65536, both counts include this pixel
    lhs   = {sel_cnt_new, {PASS_W{1'b0}}};
    rhs   = CMP_W'(pix_cnt_new) * CMP_W'(cfg_i.pass);
    below = lhs < rhs;

    if (!sel && cfg_i.dim) begin
      pix_o.y = {1'b0, pix_i.y[PIX_W-1:1]};
      pix_o.u = GREY;
      pix_o.v = GREY;
    end else begin
      pix_o = pix_i;
    end
    col_o = col_q;
    row_o = row_q;

    thr_d     = thr_q;
    col_d     = col_q;
    row_d     = row_q;
    run_d     = run_q;
    sel_cnt_d = sel_cnt_q;
    pix_cnt_d = pix_cnt_q;
    if (accept_i) begin
      if (frame_end_i) begin
        if (below) begin
          if (thr_q != '1) thr_d = thr_q + 1'b1;
        end else begin
          if (thr_q != '0) thr_d = thr_q - 1'b1;
        end
        col_d     = '0;
        row_d     = '0;
        run_d     = '0;
        sel_cnt_d = '0;
        pix_cnt_d = '0;
      end else begin
        run_d     = run_new;
        sel_cnt_d = sel_cnt_new;
        pix_cnt_d = pix_cnt_new;
        if (line_end_i) begin
          col_d = '0;
          if (row_q < ROW_W'(MAX_HEIGHT - 1)) row_d = row_q + 1'b1;
        end else begin
          if (col_q < COL_W'(MAX_WIDTH - 1)) col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THRESH_RESET;
      col_q     <= '0;
      row_q     <= '0;
      run_q     <= '0;
      sel_cnt_q <= '0;
      pix_cnt_q <= '0;
    end else begin
      thr_q     <= thr_d;
      col_q     <= col_d;
      row_q     <= row_d;
      run_q     <= run_d;
      sel_cnt_q <= sel_cnt_d;
      pix_cnt_q <= pix_cnt_d;
    end
  end

  `ASSERT_CLK(a_thr_hold, !(accept_i && frame_end_i) |=> $stable(thr_q), "threshold moved off frame end")

endmodule

// ===== src/ctct_fifo.sv =====
// ----------------------------------------------------------------------------
// ctct_fifo
// Small register queue between the classifier and the accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ctct_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_fifo_wr_full, wr_i && full_o, "queue written while full")
  `ASSERT_NEVER(a_fifo_rd_empty, rd_i && empty_o, "queue read while empty")

endmodule

// ===== src/ctct_back.sv =====
// ----------------------------------------------------------------------------
// ctct_back
// Accumulator and centroid unit: weighted products, saturating sums, a
// bit-serial divider for the frame report, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ctct_back #(
  parameter int unsigned COL_W = 10,
  parameter int unsigned ROW_W = 10,
  parameter int unsigned WT_W  = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_take_o,
  input  ctct_pkg::pix_t                in_pix_i,
  input  logic                          in_fe_i,
  input  logic [WT_W-1:0]               in_wt_i,
  input  logic [COL_W-1:0]              in_col_i,
  input  logic [ROW_W-1:0]              in_row_i,
  input  logic [ctct_pkg::MINW_W-1:0]   minw_i,
  output logic                          out_valid_o,
  input  logic                          out_pop_i,
  output ctct_pkg::pix_t                out_pix_o,
  output ctct_pkg::report_t             out_rep_o
);
  import ctct_pkg::*;

  localparam int unsigned PX_W = COL_W + WT_W;
  localparam int unsigned PY_W = ROW_W + WT_W;

  // product stage
  logic             m_valid_q;
  pix_t             m_pix_q;
  logic             m_fe_q;
  logic [WT_W-1:0]  m_wt_q;
  logic [PX_W-1:0]  m_px_q;
  logic [PY_W-1:0]  m_py_q;

  // frame sums
  logic [WSUM_W-1:0] wx_q, wy_q;
  logic [WTOT_W-1:0] wt_q;
  logic [WSUM_W:0]   sx, sy;
  logic [WTOT_W:0]   st;

  // divider
  back_state_e          st_q, st_d;
  pix_t                 hold_pix_q;
  logic                 found_q;
  logic [NUM_W-1:0]     numx_q, numy_q, dsh_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 clx_q, cly_q;
  logic [CENTRE_W-1:0]  qx_q, qy_q;
  logic                 geq_x, geq_y;

  // result register
  logic    out_valid_q;
  pix_t    out_pix_q;
  report_t out_rep_q;

  logic out_free;
  logic m_take;
  logic out_load;
  logic out_is_rep;

  always_comb begin
    out_free  = !out_valid_q || out_pop_i;
    m_take    = m_valid_q && (st_q == BK_RUN) && (m_fe_q || out_free);
    in_take_o = in_valid_i && (!m_valid_q || m_take);

    sx = {1'b0, wx_q} + (WSUM_W + 1)'(m_px_q);
    sy = {1'b0, wy_q} + (WSUM_W + 1)'(m_py_q);
    st = {1'b0, wt_q} + (WTOT_W + 1)'(m_wt_q);

    geq_x = numx_q >= dsh_q;
    geq_y = numy_q >= dsh_q;
  end

  always_comb begin
    st_d       = st_q;
    out_load   = 1'b0;
    out_is_rep = 1'b0;
    case (st_q)
      BK_RUN: begin
        if (m_take && m_fe_q) begin
          st_d = BK_LOAD;
        end else if (m_take) begin
          out_load = 1'b1;
        end
      end
      BK_LOAD: st_d = BK_DIV;
      BK_DIV: begin
        if (cnt_q == '0) st_d = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_is_rep = 1'b1;
          st_d       = BK_RUN;
        end
      end
      default: st_d = BK_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= BK_RUN;
      m_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (in_take_o) begin
        m_valid_q <= 1'b1;
      end else if (m_take) begin
        m_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sums start at zero after reset and again in the load step of every frame report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q <= '0;
      wy_q <= '0;
      wt_q <= '0;
    end else if (st_q == BK_LOAD) begin
      wx_q <= '0;
      wy_q <= '0;
      wt_q <= '0;
    end else if (m_take) begin
      wx_q <= sx[WSUM_W] ? '1 : sx[WSUM_W-1:0];
      wy_q <= sy[WSUM_W] ? '1 : sy[WSUM_W-1:0];
      wt_q <= st[WTOT_W] ? '1 : st[WTOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_o) begin
      m_pix_q <= in_pix_i;
      m_fe_q  <= in_fe_i;
      m_wt_q  <= in_wt_i;
      m_px_q  <= PX_W'(in_col_i) * PX_W'(in_wt_i);
      m_py_q  <= PY_W'(in_row_i) * PY_W'(in_wt_i);
    end

    if (m_take && m_fe_q) hold_pix_q <= m_pix_q;

    // restoring division of (2*sum + total) by (2*total); first step only
    // checks for a quotient past the centre range
    if (st_q == BK_LOAD) begin
      found_q <= wt_q > WTOT_W'(minw_i);
      numx_q  <= NUM_W'({wx_q, 1'b0}) + NUM_W'(wt_q);
      numy_q  <= NUM_W'({wy_q, 1'b0}) + NUM_W'(wt_q);
      dsh_q   <= NUM_W'(wt_q) << (CENTRE_W + 1);
      cnt_q   <= DIV_CNT_W'(CENTRE_W);
    end else if (st_q == BK_DIV) begin
      if (cnt_q == DIV_CNT_W'(CENTRE_W)) begin
        clx_q <= geq_x;
        cly_q <= geq_y;
      end else begin
        if (geq_x) numx_q <= numx_q - dsh_q;
        if (geq_y) numy_q <= numy_q - dsh_q;
        qx_q <= {qx_q[CENTRE_W-2:0], geq_x};
        qy_q <= {qy_q[CENTRE_W-2:0], geq_y};
      end
      dsh_q <= dsh_q >> 1;
      if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
    end

    if (out_load) begin
      if (out_is_rep) begin
        out_pix_q       <= hold_pix_q;
        out_rep_q.valid <= 1'b1;
        out_rep_q.found <= found_q;
        out_rep_q.cx    <= !found_q ? '0 : (clx_q ? CENTRE_MAX : qx_q);
        out_rep_q.cy    <= !found_q ? '0 : (cly_q ? CENTRE_MAX : qy_q);
      end else begin
        out_pix_q <= m_pix_q;
        out_rep_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign out_rep_o   = out_rep_q;

  `ASSERT_CLK(a_load_to_div, st_q == BK_LOAD |=> st_q == BK_DIV,
              "divider did not start")
  `ASSERT_CLK(a_div_count,
              (st_q == BK_DIV && cnt_q != '0) |=>
              (st_q == BK_DIV && cnt_q == $past(cnt_q) - 1'b1),
              "divider step lost")

endmodule

// ===== src/chroma_threshold_centroid_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// chroma_threshold_centroid_tracker_unit
// Color threshold tracker: one result pixel per input pixel, with a weighted
// centroid report on each frame's last pixel.
// ----------------------------------------------------------------------------
// Use:
//   Pixels enter on a queue-style port: a transfer happens when push is high
//   and full is low. Results leave the same way: while empty is low the
//   oldest result sits on the out_* / report ports, popped when pop is high.
//   The cfg port (valid/ready, always ready) writes show_unselected_dimmed,
//   pass_fraction and min_weight_total; write only while the block is idle.
// Timing:
//   An ordinary pixel reaches the output through the queue write at the
//   transfer edge, the product stage and the result register, and the block
//   takes one pixel per cycle while full is low. A frame-end pixel sends the
//   back end through a load step, an 11-step bit-serial divider for the two
//   centres, and a hand-off to the result register. The queue has 3 free
//   entries at full rate.
// Reset and stalls:
//   Reset empties the pipeline, sets the threshold to 80, clears the frame
//   sums and loads the register defaults. If pop stays low, the result
//   register holds, the queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chroma_threshold_centroid_tracker_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_RUN    = 4095
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel input
  input  logic                              push,
  output logic                              full,
  input  logic [ctct_pkg::PIX_W-1:0]        luma_i,
  input  logic [ctct_pkg::PIX_W-1:0]        chroma_u_i,
  input  logic [ctct_pkg::PIX_W-1:0]        chroma_v_i,
  input  logic                              line_end_i,
  input  logic                              frame_end_i,
  // result output
  output logic                              empty,
  input  logic                              pop,
  output logic [ctct_pkg::PIX_W-1:0]        out_luma_o,
  output logic [ctct_pkg::PIX_W-1:0]        out_u_o,
  output logic [ctct_pkg::PIX_W-1:0]        out_v_o,
  output logic                              report_valid_o,
  output logic                              found_o,
  output logic [ctct_pkg::CENTRE_W-1:0]     centre_x_o,
  output logic [ctct_pkg::CENTRE_W-1:0]     centre_y_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ctct_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ctct_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ctct_pkg::*;

  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned RUN_W   = $clog2(MAX_RUN + 1);
  localparam int unsigned WT_W    = 2 * RUN_W - 2;
  localparam int unsigned ENTRY_W = 3 * PIX_W + 1 + WT_W + COL_W + ROW_W;

  cfg_t cfg_q;

  pix_t             in_pix;
  pix_t             f_pix;
  logic [WT_W-1:0]  f_wt;
  logic [COL_W-1:0] f_col;
  logic [ROW_W-1:0] f_row;
  logic             accept;

  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  logic               q_empty, q_rd;

  pix_t             b_pix;
  logic             b_fe;
  logic [WT_W-1:0]  b_wt;
  logic [COL_W-1:0] b_col;
  logic [ROW_W-1:0] b_row;

  logic    out_valid;
  pix_t    out_pix;
  report_t out_rep;

  // register file; reads are not supported, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dim  <= DIM_RESET;
      cfg_q.pass <= PASS_RESET;
      cfg_q.minw <= MINW_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DIM:  cfg_q.dim  <= cfg_data_i[0];
        CFG_PASS: cfg_q.pass <= cfg_data_i[PASS_W-1:0];
        CFG_MINW: cfg_q.minw <= cfg_data_i[MINW_W-1:0];
        default:  ;
      endcase
    end
  end

  assign in_pix.y = luma_i;
  assign in_pix.u = chroma_u_i;
  assign in_pix.v = chroma_v_i;
  assign accept   = push && !full;

  ctct_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RUN    (MAX_RUN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .pix_i       (in_pix),
    .line_end_i  (line_end_i),
    .frame_end_i (frame_end_i),
    .cfg_i       (cfg_q),
    .pix_o       (f_pix),
    .wt_o        (f_wt),
    .col_o       (f_col),
    .row_o       (f_row)
  );

  // queue entry: output pixel, frame mark, run weight and raster position
  assign q_wdata = {f_pix, frame_end_i, f_wt, f_col, f_row};

  ctct_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .full_o  (full),
    .empty_o (q_empty)
  );

  assign {b_pix, b_fe, b_wt, b_col, b_row} = q_rdata;

  ctct_back #(
    .COL_W (COL_W),
    .ROW_W (ROW_W),
    .WT_W  (WT_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!q_empty),
    .in_take_o   (q_rd),
    .in_pix_i    (b_pix),
    .in_fe_i     (b_fe),
    .in_wt_i     (b_wt),
    .in_col_i    (b_col),
    .in_row_i    (b_row),
    .minw_i      (cfg_q.minw),
    .out_valid_o (out_valid),
    .out_pop_i   (pop && out_valid),
    .out_pix_o   (out_pix),
    .out_rep_o   (out_rep)
  );

  assign empty          = !out_valid;
  assign out_luma_o     = out_pix.y;
  assign out_u_o        = out_pix.u;
  assign out_v_o        = out_pix.v;
  assign report_valid_o = out_rep.valid;
  assign found_o        = out_rep.found;
  assign centre_x_o     = out_rep.cx;
  assign centre_y_o     = out_rep.cy;

endmodule
